// ===== design/tcts_pkg.sv =====
`timescale 1ns / 1ps

package tcts_pkg;

  // Default geometry
  localparam int DEF_PAGE_COUNT = 8;
  localparam int DEF_COLUMNS    = 80;
  localparam int DEF_ROWS       = 25;

  // Cell contents
  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  BLANK_CHAR = 8'h20;

  // Teletype control characters
  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  typedef enum logic [2:0] {
    OP_TTY     = 3'd0,
    OP_SCR_UP  = 3'd1,
    OP_SCR_DN  = 3'd2,
    OP_SET_CUR = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] page_sel;
    logic [7:0] char_code;
    logic [7:0] line_count;
    logic [7:0] fill_attr;
    logic [7:0] top_row;
    logic [7:0] left_col;
    logic [7:0] bottom_row;
    logic [7:0] right_col;
    logic [7:0] new_row;
    logic [7:0] new_col;
  } req_t;

  typedef struct packed {
    logic       bell;
    logic [7:0] cursor_row_out;
    logic [7:0] cursor_col_out;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CELL_RD,
    ST_TTY_WR,
    ST_ATTR_RD,
    ST_SC_SETUP,
    ST_SC_RD,
    ST_SC_WR,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic take_req;
    logic cur_set;
    logic tty_step;
    logic rd_cur;
    logic cell_wr;
    logic rd_attr;
    logic sc_setup;
    logic sc_tty;
    logic sc_rd;
    logic sc_wr;
    logic load_res;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       page_bad;
    logic [2:0] op;
    logic       cur_in;
    logic       ch_bel;
    logic       ch_ctl;
    logic       tty_scroll;
    logic       win_bad;
    logic       sc_done;
    logic       out_free;
  } sts_t;

endpackage

// ===== design/text_console_teletype_scroll_core.sv =====
// Path (beat accepted to result ready): set cursor and unused ops decode, then finish;
// read cell adds a cell read; a printable char reads and writes its cell; a teletype
// char that scrolls adds an attribute read and a full-page scroll. Window scroll:
// setup, then a read and a write step per cell (memory read only for copied cells).
// One item at a time; the next beat is taken after the result is loaded. Reset is
// synchronous; cursors clear at once, then memory is swept to blank with req_ready low.
`timescale 1ns / 1ps

module text_console_teletype_scroll_core import tcts_pkg::*; #(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctl_t ctl;
  sts_t sts;

  tcts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tcts_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

// ===== design/tcts_ctrl.sv =====
`timescale 1ns / 1ps

module tcts_ctrl import tcts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_e state, state_next;

  // State register; reset starts the cell clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = ST_FINISH;
        if (!sts.page_bad) begin
          case (sts.op)
            OP_TTY: begin
              if (sts.cur_in && !sts.ch_bel) begin
                if (sts.ch_ctl) begin
                  state_next = sts.tty_scroll ? ST_ATTR_RD : ST_FINISH;
                end else begin
                  state_next = ST_CELL_RD;
                end
              end
            end
            OP_SCR_UP, OP_SCR_DN: begin
              if (!sts.win_bad) state_next = ST_SC_SETUP;
            end
            OP_READ: begin
              if (sts.cur_in) state_next = ST_CELL_RD;
            end
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_CELL_RD: begin
        state_next = (sts.op == OP_READ) ? ST_FINISH : ST_TTY_WR;
      end
      ST_TTY_WR: begin
        state_next = sts.tty_scroll ? ST_ATTR_RD : ST_FINISH;
      end
      ST_ATTR_RD:  state_next = ST_SC_SETUP;
      ST_SC_SETUP: state_next = ST_SC_RD;
      ST_SC_RD:    state_next = ST_SC_WR;
      ST_SC_WR: begin
        state_next = sts.sc_done ? ST_FINISH : ST_SC_RD;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    ctl       = '0;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE: begin
        req_ready    = 1'b1;
        ctl.take_req = req_valid;
      end
      ST_DECODE: begin
        ctl.cur_set  = !sts.page_bad && (sts.op == OP_SET_CUR);
        ctl.tty_step = !sts.page_bad && (sts.op == OP_TTY) && sts.cur_in && sts.ch_ctl;
      end
      ST_CELL_RD: ctl.rd_cur = 1'b1;
      ST_TTY_WR: begin
        ctl.cell_wr  = 1'b1;
        ctl.tty_step = 1'b1;
      end
      ST_ATTR_RD: ctl.rd_attr = 1'b1;
      ST_SC_SETUP: begin
        ctl.sc_setup = 1'b1;
        ctl.sc_tty   = (sts.op == OP_TTY);
      end
      ST_SC_RD:  ctl.sc_rd = 1'b1;
      ST_SC_WR:  ctl.sc_wr = 1'b1;
      ST_FINISH: ctl.load_res = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

// ===== design/tcts_datapath.sv =====
`timescale 1ns / 1ps

module tcts_datapath import tcts_pkg::*; #(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  ctl_t ctl,
  output sts_t sts
);

  localparam int PAGE_CELLS = ROWS * COLUMNS;
  localparam int DEPTH      = PAGE_COUNT * PAGE_CELLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CNT_W      = $clog2(ROWS + 1);
  localparam int SW         = ROW_W + 1;
  localparam logic [7:0] ROWS_B  = 8'(ROWS);
  localparam logic [7:0] COLS_B  = 8'(COLUMNS);
  localparam logic [3:0] PAGES_B = 4'(PAGE_COUNT);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [PAGE_W-1:0] p,
                                                  input logic [ROW_W-1:0]  r,
                                                  input logic [COL_W-1:0]  c);
    return ADDR_W'(p) * ADDR_W'(PAGE_CELLS) + ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  req_t              held;
  logic [15:0]       cursor [PAGE_COUNT];
  logic [15:0]       mem [DEPTH];
  logic [15:0]       rdata;
  logic [ADDR_W-1:0] clr_ptr;

  logic [ROW_W-1:0]  sc_first, sc_last, sc_row;
  logic [COL_W-1:0]  sc_left, sc_right, sc_col;
  logic [CNT_W-1:0]  sc_count;
  logic              sc_down;
  logic [7:0]        sc_attr;

  logic              page_bad;
  logic [PAGE_W-1:0] pg;
  logic [7:0]        cur_row, cur_col;
  logic              cur_in;
  logic              ch_bel, ch_ctl;
  logic [7:0]        nrow, ncol, row_fix;
  logic              tty_scroll;

  logic              win_bad;
  logic [7:0]        right_c8, bottom_c8, height8, cnt8;

  logic [SW-1:0]     row_x, cnt_x;
  logic              src_ok, sc_done;
  logic [ROW_W-1:0]  src_row, end_row;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr, cur_addr;
  logic [15:0]       wr_data;

  // Request register
  always_ff @(posedge clk) begin
    if (ctl.take_req) held <= req;
  end

  // Page select and cursor of the selected page
  assign page_bad = {1'b0, held.page_sel} >= PAGES_B;
  assign pg       = page_bad ? '0 : held.page_sel[PAGE_W-1:0];
  assign cur_row  = cursor[pg][15:8];
  assign cur_col  = cursor[pg][7:0];
  assign cur_in   = (cur_row < ROWS_B) && (cur_col < COLS_B);
  assign cur_addr = cell_addr(pg, cur_row[ROW_W-1:0], cur_col[COL_W-1:0]);

  // Teletype character classes and cursor motion
  assign ch_bel = (held.char_code == CH_BEL);
  assign ch_ctl = (held.char_code == CH_BS) || (held.char_code == CH_CR) ||
                  (held.char_code == CH_LF);

  always_comb begin
    nrow = cur_row;
    ncol = cur_col;
    if (held.char_code == CH_BS) begin
      if (cur_col != 8'd0) ncol = cur_col - 8'd1;
    end else if (held.char_code == CH_CR) begin
      ncol = 8'd0;
    end else if (held.char_code == CH_LF) begin
      nrow = cur_row + 8'd1;
    end else if (cur_col == COLS_B - 8'd1) begin
      ncol = 8'd0;
      nrow = cur_row + 8'd1;
    end else begin
      ncol = cur_col + 8'd1;
    end
  end

  assign tty_scroll = (nrow == ROWS_B);
  assign row_fix    = tty_scroll ? (ROWS_B - 8'd1) : nrow;

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) cursor[i] <= '0;
    end else if (ctl.cur_set) begin
      cursor[pg] <= {held.new_row, held.new_col};
    end else if (ctl.tty_step) begin
      cursor[pg] <= {row_fix, ncol};
    end
  end

  // Window check, corner clamps and line count
  assign win_bad   = (held.left_col >= COLS_B) || (held.top_row >= ROWS_B) ||
                     (held.left_col > held.right_col) || (held.top_row > held.bottom_row);
  assign right_c8  = (held.right_col > COLS_B - 8'd1) ? (COLS_B - 8'd1) : held.right_col;
  assign bottom_c8 = (held.bottom_row > ROWS_B - 8'd1) ? (ROWS_B - 8'd1) : held.bottom_row;
  assign height8   = bottom_c8 - held.top_row + 8'd1;
  assign cnt8      = (held.line_count == 8'd0 || held.line_count > height8) ?
                     height8 : held.line_count;

  // Scroll sequencer registers
  always_ff @(posedge clk) begin
    if (ctl.sc_setup) begin
      if (ctl.sc_tty) begin
        sc_first <= '0;
        sc_last  <= ROW_W'(ROWS - 1);
        sc_row   <= '0;
        sc_left  <= '0;
        sc_right <= COL_W'(COLUMNS - 1);
        sc_col   <= '0;
        sc_count <= CNT_W'(1);
        sc_down  <= 1'b0;
        sc_attr  <= rdata[15:8];
      end else begin
        sc_first <= held.top_row[ROW_W-1:0];
        sc_last  <= bottom_c8[ROW_W-1:0];
        sc_row   <= (held.op == OP_SCR_DN) ? bottom_c8[ROW_W-1:0] : held.top_row[ROW_W-1:0];
        sc_left  <= held.left_col[COL_W-1:0];
        sc_right <= right_c8[COL_W-1:0];
        sc_col   <= held.left_col[COL_W-1:0];
        sc_count <= cnt8[CNT_W-1:0];
        sc_down  <= (held.op == OP_SCR_DN);
        sc_attr  <= held.fill_attr;
      end
    end else if (ctl.sc_wr) begin
      if (sc_col == sc_right) begin
        sc_col <= sc_left;
        sc_row <= sc_down ? sc_row - ROW_W'(1) : sc_row + ROW_W'(1);
      end else begin
        sc_col <= sc_col + COL_W'(1);
      end
    end
  end

  // Source row of the current cell; rows past the count are blanked
  assign row_x   = SW'(sc_row);
  assign cnt_x   = SW'(sc_count);
  assign src_ok  = sc_down ? (row_x >= SW'(sc_first) + cnt_x) : (row_x + cnt_x <= SW'(sc_last));
  assign src_row = ROW_W'(sc_down ? row_x - cnt_x : row_x + cnt_x);
  assign end_row = sc_down ? sc_first : sc_last;
  assign sc_done = (sc_col == sc_right) && (sc_row == end_row);

  // Cell memory ports
  always_comb begin
    rd_en   = ctl.rd_cur || ctl.rd_attr || (ctl.sc_rd && src_ok);
    rd_addr = cell_addr(pg, src_row, sc_col);
    if (ctl.rd_cur) begin
      rd_addr = cur_addr;
    end else if (ctl.rd_attr) begin
      rd_addr = cell_addr(pg, ROW_W'(ROWS - 1), '0);
    end
  end

  always_comb begin
    wr_en   = ctl.clr_step || ctl.cell_wr || ctl.sc_wr;
    wr_addr = cell_addr(pg, sc_row, sc_col);
    wr_data = src_ok ? rdata : {sc_attr, BLANK_CHAR};
    if (ctl.clr_step) begin
      wr_addr = clr_ptr;
      wr_data = BLANK_CELL;
    end else if (ctl.cell_wr) begin
      wr_addr = cur_addr;
      wr_data = {rdata[15:8], held.char_code};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Clearing sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (ctl.clr_step) begin
      clr_ptr <= clr_ptr + ADDR_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_res) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_res) begin
      rsp.bell           <= !page_bad && (held.op == OP_TTY) && cur_in && ch_bel;
      rsp.cursor_row_out <= page_bad ? 8'd0 : cur_row;
      rsp.cursor_col_out <= page_bad ? 8'd0 : cur_col;
      if (!page_bad && (held.op == OP_READ) && cur_in) begin
        rsp.cell_char <= rdata[7:0];
        rsp.cell_attr <= rdata[15:8];
      end else begin
        rsp.cell_char <= 8'd0;
        rsp.cell_attr <= 8'd0;
      end
    end
  end

  // Status
  always_comb begin
    sts.clr_last   = (clr_ptr == ADDR_W'(DEPTH - 1));
    sts.page_bad   = page_bad;
    sts.op         = held.op;
    sts.cur_in     = cur_in;
    sts.ch_bel     = ch_bel;
    sts.ch_ctl     = ch_ctl;
    sts.tty_scroll = tty_scroll;
    sts.win_bad    = win_bad;
    sts.sc_done    = sc_done;
    sts.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

// ===== design/tcts_checker.sv =====
`timescale 1ns / 1ps

module tcts_checker import tcts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic       have_op;
  logic [2:0] op_q;

  // Op of the item in flight, dropped once its result has been loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      have_op <= 1'b0;
    end else if (req_valid && req_ready) begin
      have_op <= 1'b1;
    end else if (req_ready) begin
      have_op <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) op_q <= req.op;
  end

  // One item at a time: accepting a beat drops ready
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req_ready stayed high after an accepted beat");

  // Reset holds off input and output while the memory is swept
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (!req_ready && !rsp_valid))
    else $error("handshake active right after reset");

  // Ready returns only once the result of the item is in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    ($rose(req_ready) && have_op) |-> rsp_valid)
    else $error("item finished without a result");

  // Cell fields only for read cell, bell only for teletype
  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    ($rose(req_ready) && have_op) |->
      ((op_q == OP_READ) || (rsp.cell_char == 8'd0 && rsp.cell_attr == 8'd0)) &&
      ((op_q == OP_TTY) || !rsp.bell))
    else $error("result field set for wrong op");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind text_console_teletype_scroll_core tcts_checker u_tcts_checker (.*);

// ===== tb/tb_text_console_teletype_scroll_core.sv =====
`timescale 1ns / 1ps

module tb_text_console_teletype_scroll_core;
  import tcts_pkg::*;

  localparam int NPAGES = DEF_PAGE_COUNT;
  localparam int NCOLS  = DEF_COLUMNS;
  localparam int NROWS  = DEF_ROWS;

  // Op codes the block leaves undecoded
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  // No beat on either side for this long means the block is hung; covers the
  // clear sweep after reset and a full-page scroll several times over.
  localparam int HANG_LIMIT     = 64000;
  localparam int RX_HOLD_CYCLES = 240;
  localparam int MAX_MSG        = 40;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  text_console_teletype_scroll_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the console: cell words and per-page cursors
  logic [15:0] screen [NPAGES*NROWS*NCOLS];
  logic [15:0] cursor [NPAGES];
  rsp_t        pending_status [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit rx_hold_start = 1'b0;
  int rx_hold_left  = 0;
  int idle_cycles   = 0;

  int mismatch_count = 0;
  int items_sent     = 0;
  int status_checked = 0;
  int bell_count     = 0;
  int scroll_count   = 0;
  int read_hits      = 0;

  function automatic int cell_idx(int pg, int row, int col);
    return (pg * NROWS + row) * NCOLS + col;
  endfunction

  // Move a window by count lines; rows coming in are blank with attr
  function automatic void shift_window(int pg, bit down, int count, logic [7:0] attr,
                                       int top, int left, int bot, int right);
    int height;
    int row;
    int x;
    int y;
    logic [15:0] v;
    if (left >= NCOLS || top >= NROWS || left > right || top > bot) return;
    if (right > NCOLS - 1) right = NCOLS - 1;
    if (bot > NROWS - 1) bot = NROWS - 1;
    height = bot - top + 1;
    if (count == 0 || count > height) count = height;
    scroll_count++;
    for (y = 0; y < height; y++) begin
      row = down ? bot - y : top + y;
      for (x = left; x <= right; x++) begin
        v = {attr, BLANK_CHAR};
        if (down ? (row >= top + count) : (row + count <= bot))
          v = screen[cell_idx(pg, down ? row - count : row + count, x)];
        screen[cell_idx(pg, row, x)] = v;
      end
    end
  endfunction

  // Teletype one character; returns the bell flag
  function automatic bit type_char(int pg, logic [7:0] ch);
    int row;
    int col;
    int i;
    row = int'(cursor[pg][15:8]);
    col = int'(cursor[pg][7:0]);
    if (row >= NROWS || col >= NCOLS) return 1'b0;
    if (ch == CH_BEL) return 1'b1;
    if (ch == CH_BS) begin
      if (col != 0) col--;
    end else if (ch == CH_CR) begin
      col = 0;
    end else if (ch == CH_LF) begin
      row++;
    end else begin
      i = cell_idx(pg, row, col);
      screen[i] = {screen[i][15:8], ch};
      col++;
      if (col == NCOLS) begin
        col = 0;
        row++;
      end
    end
    // past the last row: whole page up one, blank with attr of bottom-left cell
    if (row == NROWS) begin
      shift_window(pg, 1'b0, 1, screen[cell_idx(pg, NROWS - 1, 0)][15:8],
                   0, 0, NROWS - 1, NCOLS - 1);
      row--;
    end
    cursor[pg] = {8'(row), 8'(col)};
    return 1'b0;
  endfunction

  // Apply one request to the shadow console and return the status it yields
  function automatic rsp_t console_status(req_t item);
    rsp_t s;
    int pg;
    int crow;
    int ccol;
    logic [15:0] v;
    s = '0;
    pg = int'(item.page_sel);
    if (pg >= NPAGES) return s;
    case (item.op)
      OP_TTY: begin
        s.bell = type_char(pg, item.char_code);
        if (s.bell) bell_count++;
      end
      OP_SCR_UP, OP_SCR_DN: begin
        shift_window(pg, item.op == OP_SCR_DN, int'(item.line_count), item.fill_attr,
                     int'(item.top_row), int'(item.left_col), int'(item.bottom_row),
                     int'(item.right_col));
      end
      OP_SET_CUR: begin
        cursor[pg] = {item.new_row, item.new_col};
      end
      OP_READ: begin
        crow = int'(cursor[pg][15:8]);
        ccol = int'(cursor[pg][7:0]);
        if (crow < NROWS && ccol < NCOLS) begin
          v = screen[cell_idx(pg, crow, ccol)];
          s.cell_char = v[7:0];
          s.cell_attr = v[15:8];
          read_hits++;
        end
      end
      default: ;
    endcase
    s.cursor_row_out = cursor[pg][15:8];
    s.cursor_col_out = cursor[pg][7:0];
    return s;
  endfunction

  // Request builders; fields the op ignores carry random junk
  function automatic req_t random_req();
    req_t r;
    r.op         = 3'($urandom_range(OP_TTY, OP_UNUSED_LAST));
    r.page_sel   = 3'($urandom_range(0, NPAGES - 1));
    r.char_code  = 8'($urandom_range(0, 255));
    r.line_count = 8'($urandom_range(0, 255));
    r.fill_attr  = 8'($urandom_range(0, 255));
    r.top_row    = 8'($urandom_range(0, 255));
    r.left_col   = 8'($urandom_range(0, 255));
    r.bottom_row = 8'($urandom_range(0, 255));
    r.right_col  = 8'($urandom_range(0, 255));
    r.new_row    = 8'($urandom_range(0, 255));
    r.new_col    = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic req_t mk_tty(int pg, logic [7:0] ch);
    req_t r;
    r = random_req();
    r.op = OP_TTY;
    r.page_sel = 3'(pg);
    r.char_code = ch;
    return r;
  endfunction

  function automatic req_t mk_cursor(int pg, int row, int col);
    req_t r;
    r = random_req();
    r.op = OP_SET_CUR;
    r.page_sel = 3'(pg);
    r.new_row = 8'(row);
    r.new_col = 8'(col);
    return r;
  endfunction

  function automatic req_t mk_read(int pg);
    req_t r;
    r = random_req();
    r.op = OP_READ;
    r.page_sel = 3'(pg);
    return r;
  endfunction

  function automatic req_t mk_scroll(int pg, bit down, int count, int attr,
                                     int top, int left, int bot, int right);
    req_t r;
    r = random_req();
    r.op = down ? OP_SCR_DN : OP_SCR_UP;
    r.page_sel = 3'(pg);
    r.line_count = 8'(count);
    r.fill_attr = 8'(attr);
    r.top_row = 8'(top);
    r.left_col = 8'(left);
    r.bottom_row = 8'(bot);
    r.right_col = 8'(right);
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return CH_BEL;
      1: return CH_BS;
      2: return CH_CR;
      3, 4: return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one request beat, hold it until taken, then queue its status
  task automatic send_item(req_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    pending_status.push_back(console_status(item));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold_start) begin
      rx_hold_start = 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_MSG)
        $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
    end
  endtask

  // Status checker: each beat against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_MSG)
          $display("%0t: unexpected status beat, expected none, actual %h", $time, rsp);
      end else begin
        want = pending_status.pop_front();
        status_checked++;
        check_field("bell", 8'(want.bell), 8'(rsp.bell));
        check_field("cursor_row_out", want.cursor_row_out, rsp.cursor_row_out);
        check_field("cursor_col_out", want.cursor_col_out, rsp.cursor_col_out);
        check_field("cell_char", want.cell_char, rsp.cell_char);
        check_field("cell_attr", want.cell_attr, rsp.cell_attr);
      end
    end
  end

  // Hang watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d status beats outstanding",
                 $time, HANG_LIMIT, pending_status.size());
        $display("text_console_teletype_scroll_core verification failed");
        $finish;
      end
    end
  end

  // Printable, control and edge characters, backspace at column 0
  task automatic test_teletype_basics();
    send_item(mk_read(0));
    send_item(mk_tty(0, 8'h41));
    send_item(mk_tty(0, 8'hff));
    send_item(mk_tty(0, 8'h00));
    send_item(mk_tty(0, CH_BEL));
    send_item(mk_tty(0, CH_BS));
    send_item(mk_tty(0, CH_CR));
    send_item(mk_tty(0, CH_BS));
    send_item(mk_read(0));
    send_item(mk_tty(0, CH_LF));
  endtask

  // Wrap off the last cell and line feed on the last row both scroll the page
  task automatic test_teletype_page_scroll();
    send_item(mk_cursor(7, NROWS - 1, NCOLS - 1));
    send_item(mk_tty(7, 8'h5a));
    send_item(mk_tty(7, CH_LF));
  endtask

  // Cursor off the page: no bell, no write, zero read
  task automatic test_cursor_outside();
    send_item(mk_cursor(5, 255, 255));
    send_item(mk_tty(5, CH_BEL));
    send_item(mk_read(5));
    send_item(mk_cursor(5, 0, NCOLS));
    send_item(mk_tty(5, 8'h78));
  endtask

  // Rejected corners, clamping, clear on zero and oversized counts
  task automatic test_window_scroll();
    send_item(mk_scroll(3, 1'b0, 1, 'h11, 0, NCOLS, 5, 90));
    send_item(mk_scroll(3, 1'b0, 1, 'h11, NROWS, 0, 30, 10));
    send_item(mk_scroll(3, 1'b1, 1, 'h11, 0, 10, 5, 5));
    send_item(mk_scroll(3, 1'b1, 1, 'h11, 9, 0, 4, 10));
    send_item(mk_scroll(3, 1'b0, 0, 'hff, 0, 0, 255, 255));
    send_item(mk_scroll(3, 1'b1, 200, 'h1e, 2, 3, 6, 9));
    send_item(mk_scroll(3, 1'b0, 1, 'h00, 1, 5, 4, 12));
    send_item(mk_cursor(3, 3, 5));
    send_item(mk_read(3));
  endtask

  task automatic test_unused_ops();
    req_t r;
    r = random_req();
    r.op = OP_UNUSED_FIRST;
    send_item(r);
    r = random_req();
    r.op = OP_UNUSED_LAST;
    send_item(r);
  endtask

  // Mostly well-formed sequences with random content, some noise
  task automatic test_random_traffic(int n);
    int stop_at;
    int kind;
    int pg;
    int top;
    int left;
    int bot;
    int right;
    req_t r;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      pg = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, NPAGES - 1);
      if (kind < 35) begin
        // a line of text, often near the bottom or the row end
        if ($urandom_range(0, 4) != 0)
          send_item(mk_cursor(pg,
            $urandom_range(0, 2) == 0 ? $urandom_range(0, NROWS - 1)
                                      : $urandom_range(NROWS - 4, NROWS - 1),
            $urandom_range(0, 2) == 0 ? $urandom_range(NCOLS - 6, NCOLS - 1)
                                      : $urandom_range(0, NCOLS - 1)));
        repeat ($urandom_range(2, 10)) send_item(mk_tty(pg, pick_char()));
        send_item(mk_tty(pg, CH_BS));
        send_item(mk_read(pg));
      end else if (kind < 60) begin
        // window scroll, then probe inside the window
        top = $urandom_range(0, NROWS - 1);
        left = $urandom_range(0, NCOLS - 1);
        if ($urandom_range(0, 9) == 0) begin
          bot = $urandom_range(top, 255);
          right = $urandom_range(left, 255);
        end else begin
          bot = top + $urandom_range(0, 4);
          right = left + $urandom_range(0, 8);
        end
        send_item(mk_scroll(pg, 1'($urandom_range(0, 1)), $urandom_range(0, 7),
                            $urandom_range(0, 255), top, left, bot, right));
        if (bot > NROWS - 1) bot = NROWS - 1;
        if (right > NCOLS - 1) right = NCOLS - 1;
        repeat ($urandom_range(1, 3)) begin
          send_item(mk_cursor(pg, $urandom_range(top, bot), $urandom_range(left, right)));
          send_item(mk_read(pg));
        end
      end else if (kind < 70) begin
        if ($urandom_range(0, 1))
          send_item(mk_cursor(pg, $urandom_range(0, NROWS - 1), $urandom_range(0, NCOLS - 1)));
        send_item(mk_read(pg));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 3)) send_item(random_req());
      end else if (kind < 88) begin
        if ($urandom_range(0, 1))
          send_item(mk_cursor(pg, $urandom_range(NROWS, 255), $urandom_range(0, 255)));
        else
          send_item(mk_cursor(pg, $urandom_range(0, 255), $urandom_range(NCOLS, 255)));
        send_item(mk_tty(pg, pick_char()));
        send_item(mk_read(pg));
      end else begin
        r = random_req();
        r.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        send_item(r);
        send_item(mk_cursor(pg, $urandom_range(0, 255), $urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_backpressure(int pg);
    int saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    rx_hold_start = 1'b1;
    send_item(mk_cursor(pg, 3, 7));
    repeat (4) send_item(mk_tty(pg, 8'($urandom_range(33, 126))));
    send_item(mk_tty(pg, CH_BS));
    send_item(mk_read(pg));
    send_idle_pct = saved_idle;
  endtask

  // Sender goes quiet until every status has come back
  task automatic test_pause_until_drained(int pg);
    wait_drained();
    send_item(mk_read(pg));
  endtask

  initial begin
    int i;
    for (i = 0; i < NPAGES * NROWS * NCOLS; i++) screen[i] = BLANK_CELL;
    for (i = 0; i < NPAGES; i++) cursor[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 73;
    test_teletype_basics();
    test_teletype_page_scroll();
    test_cursor_outside();
    test_window_scroll();
    test_unused_ops();
    test_random_traffic(35);
    test_output_backpressure(1);
    test_pause_until_drained(1);

    send_idle_pct = 73;
    recv_idle_pct = 35;
    test_random_traffic(35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(35);
    test_output_backpressure(6);

    wait_drained();
    repeat (16) @(posedge clk);
    $display("Run covered %0d requests: %0d bells, %0d scroll passes, %0d in-page reads.",
             items_sent, bell_count, scroll_count, read_hits);
    $display("Checked %0d status beats, %0d field mismatches.", status_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("text_console_teletype_scroll_core verification clean");
    end else begin
      $display("text_console_teletype_scroll_core verification failed");
    end
    $finish;
  end

endmodule

// ===== text_console_teletype_scroll_core.f =====
design/tcts_pkg.sv
design/tcts_ctrl.sv
design/tcts_datapath.sv
design/text_console_teletype_scroll_core.sv
design/tcts_checker.sv
tb/tb_text_console_teletype_scroll_core.sv
